FILE: rtl/ssg_pkg.sv
// Shared constants, sequencer codes, types and helpers for the sensor smoothing gate.
package ssg_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned VAL_W           = 32;
  localparam int unsigned ALPHA_W         = 17;
  localparam int unsigned BAND_W          = 31;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 32;
  localparam int unsigned FILL_W          = 2;

  localparam logic [ALPHA_W-1:0] ONE_Q16   = 17'd65536;
  localparam logic [FILL_W-1:0]  MED_TAPS  = 2'd3;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_CAL_SCALE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EMA_ALPHA  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MEDIAN_ON  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HYST_WIDTH = 3'd6;

  // Sequencer steps
  localparam int unsigned ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE = 3'd0;  // wait for a sample
  localparam logic [ST_W-1:0] ST_MCAL = 3'd1;  // multiply scale by raw
  localparam logic [ST_W-1:0] ST_SAT  = 3'd2;  // add offset, saturate
  localparam logic [ST_W-1:0] ST_MA   = 3'd3;  // multiply alpha by new value
  localparam logic [ST_W-1:0] ST_MB   = 3'd4;  // multiply (1-alpha) by previous
  localparam logic [ST_W-1:0] ST_SUM  = 3'd5;  // sum and round the average
  localparam logic [ST_W-1:0] ST_FILT = 3'd6;  // median window
  localparam logic [ST_W-1:0] ST_GATE = 3'd7;  // comparator, deadband, result

  typedef struct packed {
    logic start;       // sample accepted this cycle
    logic ema_bypass;  // calibrated value goes straight to the median stage
    logic out_free;    // result register can take a new beat
  } ssg_stat_t;

  function automatic logic signed [VAL_W-1:0] mid3(input logic signed [VAL_W-1:0] a,
                                                   input logic signed [VAL_W-1:0] b,
                                                   input logic signed [VAL_W-1:0] c);
    logic signed [VAL_W-1:0] lo;
    logic signed [VAL_W-1:0] hi;
    logic signed [VAL_W-1:0] m;
    lo = (a > b) ? b : a;
    hi = (a > b) ? a : b;
    if (c >= hi) begin
      m = hi;
    end else if (c <= lo) begin
      m = lo;
    end else begin
      m = c;
    end
    return m;
  endfunction

endpackage

FILE: rtl/sensor_smooth_gate_pipeline_unit.sv
// Top level of the single-channel sensor smoothing and gating block.
//
// One raw signed sample enters per input beat and produces exactly one result
// beat. The sample is calibrated as cal_scale*raw+cal_offset and saturated to
// signed Q15.16, smoothed by an exponential moving average (the first sample
// seeds it, alpha of 1.0 or more passes the value through), optionally run
// through a three-sample median (the first two samples pass through), then a
// hysteresis comparator around threshold sets level_active (hyst_width of zero
// holds the flag) and a deadband gate sets report (the first sample always
// reports). One multiplier is shared by the calibration and both EMA terms, so
// a sample takes one multiplier pass for calibration and two more for the
// average, which are skipped when the average is bypassed (first sample, alpha
// at 1.0 or above); the block takes no new sample until the last one has left
// the gate step. in_stall_o is high while a sample is at work. The result
// sits in an output register, so the next sample is accepted while the previous
// result still waits; a new result waits in the last step until that register
// frees. Configuration beats are taken while no sample is at work; any write to
// a defined register clears all filter state, and a write to an undefined index
// is dropped.
module sensor_smooth_gate_pipeline_unit import ssg_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Sample input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] raw_sample_i,
  // Result output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [VAL_W-1:0]       filtered_value_o,
  output logic                          report_o,
  output logic                          level_active_o,
  // Configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i
);

  // Multiplier B operand carries a raw sample or an 18-bit signed weight
  localparam int unsigned MUL_B_W = (SAMPLE_BITS > 18) ? SAMPLE_BITS : 18;
  localparam int unsigned PROD_W  = VAL_W + MUL_B_W;
  localparam int unsigned ACC_W   = PROD_W + 1;
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(32768);

  // Configuration registers
  logic signed [VAL_W-1:0]   cal_scale_q;
  logic signed [VAL_W-1:0]   cal_offset_q;
  logic [ALPHA_W-1:0]        ema_alpha_q;
  logic                      median_on_q;
  logic [BAND_W-1:0]         deadband_q;
  logic signed [VAL_W-1:0]   threshold_q;
  logic [BAND_W-1:0]         hyst_width_q;

  // Filter state
  logic signed [VAL_W-1:0]   ema_prev_q;
  logic                      ema_valid_q;
  logic signed [VAL_W-1:0]   win_q [MED_TAPS];
  logic [FILL_W-1:0]         fill_q;
  logic signed [VAL_W-1:0]   last_rep_q;
  logic                      has_rep_q;
  logic                      active_q;

  // Working registers for the sample at work
  logic signed [SAMPLE_BITS-1:0] raw_q;
  logic signed [VAL_W-1:0]       cal_q;
  logic signed [ACC_W-1:0]       acc_q;
  logic signed [VAL_W-1:0]       ema_q;
  logic signed [VAL_W-1:0]       val_q;

  // Result register
  logic                      out_valid_q;
  logic signed [VAL_W-1:0]   out_val_q;
  logic                      out_rep_q;
  logic                      out_act_q;

  logic [ST_W-1:0]           state;
  ssg_stat_t                 stat;
  logic                      in_fire;
  logic                      cfg_fire;
  logic                      cfg_hit;

  logic signed [VAL_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;

  assign in_stall_o  = (state != ST_IDLE);
  assign cfg_ready_o = (state == ST_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign cfg_hit     = cfg_fire && (cfg_index_i <= REG_HYST_WIDTH);

  assign stat.start      = in_fire;
  assign stat.ema_bypass = !ema_valid_q || ema_alpha_q[ALPHA_W-1];
  assign stat.out_free   = !out_valid_q || !out_stall_i;

  ssg_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stat_i  (stat),
    .state_o (state)
  );

  // Pick the operands for the shared multiplier by step
  always_comb begin
    mul_a = cal_q;
    mul_b = MUL_B_W'(ema_alpha_q[ALPHA_W-2:0]);
    case (state)
      ST_MCAL: begin
        mul_a = cal_scale_q;
        mul_b = MUL_B_W'(raw_q);
      end
      ST_MB: begin
        mul_a = ema_prev_q;
        mul_b = MUL_B_W'(ONE_Q16 - {1'b0, ema_alpha_q[ALPHA_W-2:0]});
      end
      default: begin
        mul_a = cal_q;
        mul_b = MUL_B_W'(ema_alpha_q[ALPHA_W-2:0]);
      end
    endcase
  end

  ssg_mul #(
    .A_W (VAL_W),
    .B_W (MUL_B_W)
  ) u_mul (
    .clk_i  (clk_i),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .prod_o (prod)
  );

  // Calibration: add offset to the product and clamp to Q15.16
  logic signed [ACC_W-1:0] cal_sum;
  logic signed [VAL_W-1:0] cal_sat;
  logic                    cal_fits;

  assign cal_sum  = ACC_W'(prod) + ACC_W'(cal_offset_q);
  assign cal_fits = (&cal_sum[ACC_W-1:VAL_W-1]) || !(|cal_sum[ACC_W-1:VAL_W-1]);
  assign cal_sat  = cal_fits ? cal_sum[VAL_W-1:0]
                  : (cal_sum[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}}
                                      : {1'b0, {(VAL_W-1){1'b1}}});

  // EMA: the arithmetic shift floors the rounded sum, which stays in range
  logic signed [ACC_W-1:0] ema_sum;
  logic signed [VAL_W-1:0] ema_new;

  assign ema_sum = acc_q + ACC_W'(prod);
  assign ema_new = ema_sum[VAL_W+15:16];

  // Median window: fill, then slide
  logic signed [VAL_W-1:0] val_new;
  always_comb begin
    val_new = ema_q;
    if (median_on_q) begin
      if (fill_q == MED_TAPS) begin
        val_new = mid3(win_q[1], win_q[2], ema_q);
      end else if (fill_q == FILL_W'(MED_TAPS - 2'd1)) begin
        val_new = mid3(win_q[0], win_q[1], ema_q);
      end
    end
  end

  // Comparator and deadband on the final value
  logic signed [VAL_W:0] val_x;
  logic signed [VAL_W:0] hi_bound;
  logic signed [VAL_W:0] lo_bound;
  logic signed [VAL_W:0] diff;
  logic [VAL_W:0]        diff_mag;
  logic                  act_new;
  logic                  moved;

  assign val_x    = {val_q[VAL_W-1], val_q};
  assign hi_bound = {threshold_q[VAL_W-1], threshold_q} + {2'b00, hyst_width_q};
  assign lo_bound = {threshold_q[VAL_W-1], threshold_q} - {2'b00, hyst_width_q};
  assign diff     = val_x - {last_rep_q[VAL_W-1], last_rep_q};
  assign diff_mag = diff[VAL_W] ? (VAL_W+1)'(-diff) : diff;
  assign moved    = diff_mag > {2'b00, deadband_q};

  always_comb begin
    act_new = active_q;
    if (hyst_width_q != '0) begin
      if (!active_q && (val_x >= hi_bound)) begin
        act_new = 1'b1;
      end else if (active_q && (val_x <= lo_bound)) begin
        act_new = 1'b0;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_scale_q  <= VAL_W'(ONE_Q16);
      cal_offset_q <= '0;
      ema_alpha_q  <= ONE_Q16;
      median_on_q  <= 1'b0;
      deadband_q   <= '0;
      threshold_q  <= '0;
      hyst_width_q <= '0;
    end else if (cfg_fire) begin
      unique case (cfg_index_i)
        REG_CAL_SCALE:  cal_scale_q  <= cfg_data_i;
        REG_CAL_OFFSET: cal_offset_q <= cfg_data_i;
        REG_EMA_ALPHA:  ema_alpha_q  <= cfg_data_i[ALPHA_W-1:0];
        REG_MEDIAN_ON:  median_on_q  <= cfg_data_i[0];
        REG_DEADBAND:   deadband_q   <= cfg_data_i[BAND_W-1:0];
        REG_THRESHOLD:  threshold_q  <= cfg_data_i;
        REG_HYST_WIDTH: hyst_width_q <= cfg_data_i[BAND_W-1:0];
        default: ;  // drop writes to undefined indexes
      endcase
    end
  end

  // Filter state: advance per step, clear on any defined config write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ema_prev_q  <= '0;
      ema_valid_q <= 1'b0;
      win_q[0]    <= '0;
      win_q[1]    <= '0;
      win_q[2]    <= '0;
      fill_q      <= '0;
      last_rep_q  <= '0;
      has_rep_q   <= 1'b0;
      active_q    <= 1'b0;
    end else if (cfg_hit) begin
      ema_prev_q  <= '0;
      ema_valid_q <= 1'b0;
      win_q[0]    <= '0;
      win_q[1]    <= '0;
      win_q[2]    <= '0;
      fill_q      <= '0;
      last_rep_q  <= '0;
      has_rep_q   <= 1'b0;
      active_q    <= 1'b0;
    end else begin
      case (state)
        ST_SAT: if (!ema_valid_q) begin
          ema_prev_q  <= cal_sat;
          ema_valid_q <= 1'b1;
        end
        ST_SUM: ema_prev_q <= ema_new;
        ST_FILT: if (median_on_q) begin
          if (fill_q == MED_TAPS) begin
            win_q[0] <= win_q[1];
            win_q[1] <= win_q[2];
            win_q[2] <= ema_q;
          end else begin
            win_q[fill_q] <= ema_q;
            fill_q        <= fill_q + 2'd1;
          end
        end
        ST_GATE: if (stat.out_free) begin
          active_q <= act_new;
          if (!has_rep_q || moved) begin
            last_rep_q <= val_q;
            has_rep_q  <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers of the sample at work
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      raw_q <= raw_sample_i;
    end
    if (state == ST_SAT) begin
      cal_q <= cal_sat;
      ema_q <= cal_sat;
    end
    if (state == ST_MB) begin
      acc_q <= ACC_W'(prod) + RND_HALF;
    end
    if (state == ST_SUM) begin
      ema_q <= ema_new;
    end
    if (state == ST_FILT) begin
      val_q <= val_new;
    end
  end

  // Result register: load in the last step, hold while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state == ST_GATE) && stat.out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state == ST_GATE) && stat.out_free) begin
      out_val_q <= val_q;
      out_rep_q <= !has_rep_q || moved;
      out_act_q <= act_new;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign filtered_value_o = out_val_q;
  assign report_o         = out_rep_q;
  assign level_active_o   = out_act_q;

endmodule

FILE: rtl/ssg_mul.sv
// Shared signed multiplier with a registered product.
module ssg_mul import ssg_pkg::*; #(
  parameter int unsigned A_W = 32,
  parameter int unsigned B_W = 18
) (
  input  logic                       clk_i,
  input  logic signed [A_W-1:0]      op_a_i,
  input  logic signed [B_W-1:0]      op_b_i,
  output logic signed [A_W+B_W-1:0]  prod_o
);

  logic signed [A_W+B_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= (A_W+B_W)'(op_a_i) * (A_W+B_W)'(op_b_i);
  end

  assign prod_o = prod_q;

endmodule

FILE: rtl/ssg_seq.sv
// Step sequencer that walks one sample through the shared multiplier.
module ssg_seq import ssg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ssg_stat_t        stat_i,
  output logic [ST_W-1:0]  state_o
);

  logic [ST_W-1:0] state_q;
  logic [ST_W-1:0] state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (stat_i.start) begin
        state_d = ST_MCAL;
      end
      ST_MCAL: state_d = ST_SAT;
      ST_SAT:  state_d = stat_i.ema_bypass ? ST_FILT : ST_MA;
      ST_MA:   state_d = ST_MB;
      ST_MB:   state_d = ST_SUM;
      ST_SUM:  state_d = ST_FILT;
      ST_FILT: state_d = ST_GATE;
      ST_GATE: if (stat_i.out_free) begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

FILE: rtl/ssg_checker.sv
// Port-level checks for the sensor smoothing gate, bound to the top level.
module ssg_checker import ssg_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic signed [SAMPLE_BITS-1:0] raw_sample_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [VAL_W-1:0]       filtered_value_o,
  input logic                          report_o,
  input logic                          level_active_o,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o
);

  // An accepted sample holds off the next one and the config port
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (in_stall_o && !cfg_ready_o))
    else $error("block not busy after a sample beat");

  // A result only appears at the end of work on a sample
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result beat without a sample at work");

  // Config beats never overlap work on a sample
  a_cfg_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |-> !in_stall_o)
    else $error("config beat taken while a sample is at work");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(filtered_value_o) && $stable(report_o)
       && $stable(level_active_o)))
    else $error("stalled result beat changed");

  // A stalled sample holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=> (in_valid_i && $stable(raw_sample_i)))
    else $error("stalled sample beat changed");

endmodule

bind sensor_smooth_gate_pipeline_unit ssg_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_ssg_checker (.*);

FILE: tb/tb.sv
// Self-checking testbench for sensor_smooth_gate_pipeline_unit: directed table plus random phases.
module tb import ssg_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SAMPLE_W = SAMPLE_BITS_DEF;
  // The port is three bits wide, so one index past the last register exists
  localparam logic [CFG_IDX_W-1:0] REG_UNDEFINED = 3'd7;
  // Extra wait after the last result before a batch of register writes
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 150;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int PHASES       = 12;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    report;
    logic                    active;
  } gate_result_t;

  typedef enum logic { ROW_SAMPLE, ROW_WRITE } row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    logic [CFG_IDX_W-1:0]    idx;
    logic [CFG_DATA_W-1:0]   data;    // register value, or the sample in the low bits
    logic                    pinned;  // use want instead of the prediction
    gate_result_t            want;
  } stim_row_t;

  typedef enum logic [1:0] { STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_TOGGLE } stall_mode_e;
  typedef enum logic [1:0] { WANDER, SPIKY, NOISE } sample_style_e;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] raw_sample_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic signed [VAL_W-1:0]    filtered_value_o;
  logic                       report_o;
  logic                       level_active_o;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index_i;
  logic [CFG_DATA_W-1:0]      cfg_data_i;

  sensor_smooth_gate_pipeline_unit #(
    .SAMPLE_BITS(SAMPLE_W)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .raw_sample_i    (raw_sample_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .filtered_value_o(filtered_value_o),
    .report_o        (report_o),
    .level_active_o  (level_active_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Filter mirror: register copies and the single channel's filter state
  // ---------------------------------------------------------------------------
  logic signed [VAL_W-1:0] scale_q;
  logic signed [VAL_W-1:0] offset_q;
  logic [ALPHA_W-1:0]      alpha_q;
  logic                    median_en;
  logic [BAND_W-1:0]       band_q;
  logic signed [VAL_W-1:0] thresh_q;
  logic [BAND_W-1:0]       hyst_q;

  logic signed [VAL_W-1:0] avg_prev;
  logic                    avg_seeded;
  logic signed [VAL_W-1:0] win [3];
  logic [FILL_W-1:0]       win_fill;
  logic signed [VAL_W-1:0] last_sent;
  logic                    sent_once;
  logic                    level_q;

  gate_result_t results_due[$];   // one entry per accepted sample, oldest first
  stim_row_t    directed_rows[$];
  int           mismatches;
  int           cycle_count;
  int           burst_left;
  bit           hold_req;         // ask the receiver for one long hold-off

  function automatic void clear_filter();
    avg_prev   = '0;
    avg_seeded = 1'b0;
    win[0]     = '0;
    win[1]     = '0;
    win[2]     = '0;
    win_fill   = '0;
    last_sent  = '0;
    sent_once  = 1'b0;
    level_q    = 1'b0;
  endfunction

  function automatic logic signed [VAL_W-1:0] clamp32(input longint v);
    if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'sh8000_0000;
    return v[VAL_W-1:0];
  endfunction

  // Median as clamp of the third value into the span of the other two
  function automatic logic signed [VAL_W-1:0] middle3(input logic signed [VAL_W-1:0] a,
                                                      input logic signed [VAL_W-1:0] b,
                                                      input logic signed [VAL_W-1:0] c);
    logic signed [VAL_W-1:0] lo_ab;
    logic signed [VAL_W-1:0] hi_ab;
    logic signed [VAL_W-1:0] m;
    lo_ab = (a < b) ? a : b;
    hi_ab = (a < b) ? b : a;
    m = (c < hi_ab) ? c : hi_ab;
    return (m > lo_ab) ? m : lo_ab;
  endfunction

  // Walk one sample through calibration, average, median, comparator and deadband
  function automatic gate_result_t smooth_and_gate(input logic signed [SAMPLE_W-1:0] raw);
    logic signed [VAL_W-1:0] cal;
    logic signed [VAL_W-1:0] avg;
    logic signed [VAL_W-1:0] val;
    longint                  acc;
    longint                  upper;
    longint                  lower;
    longint                  diff;
    gate_result_t            r;
    cal = clamp32(longint'(scale_q) * longint'(raw) + longint'(offset_q));

    // First sample seeds the average; alpha of one or more bypasses it
    if (!avg_seeded) begin
      avg_prev   = cal;
      avg_seeded = 1'b1;
      avg        = cal;
    end else if (alpha_q >= ONE_Q16) begin
      avg = cal;
    end else begin
      acc = longint'(alpha_q) * longint'(cal)
          + (longint'(ONE_Q16) - longint'(alpha_q)) * longint'(avg_prev) + 64'sd32768;
      avg      = clamp32(acc >>> 16);
      avg_prev = avg;
    end

    // Median window only moves while enabled; pass through until it is full
    if (!median_en) begin
      val = avg;
    end else if (win_fill < MED_TAPS) begin
      win[win_fill] = avg;
      win_fill      = win_fill + 1'b1;
      val = (win_fill < MED_TAPS) ? avg : middle3(win[0], win[1], win[2]);
    end else begin
      win[0] = win[1];
      win[1] = win[2];
      win[2] = avg;
      val    = middle3(win[0], win[1], win[2]);
    end

    // Zero half-width holds the flag
    if (hyst_q != '0) begin
      upper = longint'(thresh_q) + longint'(hyst_q);
      lower = longint'(thresh_q) - longint'(hyst_q);
      if (!level_q && longint'(val) >= upper) begin
        level_q = 1'b1;
      end else if (level_q && longint'(val) <= lower) begin
        level_q = 1'b0;
      end
    end

    if (!sent_once) begin
      last_sent = val;
      sent_once = 1'b1;
      r.report  = 1'b1;
    end else begin
      diff = longint'(val) - longint'(last_sent);
      if (diff < 0) diff = -diff;
      if (diff > longint'(band_q)) begin
        last_sent = val;
        r.report  = 1'b1;
      end else begin
        r.report = 1'b0;
      end
    end
    r.value  = val;
    r.active = level_q;
    return r;
  endfunction

  // Mirror a register beat; drop undefined indexes without touching the state
  function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_CAL_SCALE:  scale_q   = data;
      REG_CAL_OFFSET: offset_q  = data;
      REG_EMA_ALPHA:  alpha_q   = data[ALPHA_W-1:0];
      REG_MEDIAN_ON:  median_en = data[0];
      REG_DEADBAND:   band_q    = data[BAND_W-1:0];
      REG_THRESHOLD:  thresh_q  = data;
      REG_HYST_WIDTH: hyst_q    = data[BAND_W-1:0];
      default: return;
    endcase
    clear_filter();
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("tb: mismatch in %s: got %h, want %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Append at the tail of the expectation queue
  function automatic void append_result(input gate_result_t r);
    results_due.insert(results_due.size(), r);
  endfunction

  // Append at the tail of the directed table
  function automatic void append_row(input stim_row_t row);
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one sample and hold it until taken; record its expectation at the
  // accepting edge, then either keep valid up for the next beat of the burst
  // or drop it for a random gap.
  task automatic send_sample(input logic [SAMPLE_W-1:0] raw, input logic pinned,
                             input gate_result_t want);
    gate_result_t predicted;
    int           gap;
    in_valid_i   <= 1'b1;
    raw_sample_i <= raw;
    do @(posedge clk_i); while (in_stall_o);
    predicted = smooth_and_gate(raw);
    append_result(pinned ? want : predicted);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap        = $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drain: stop offering, wait for every result, then let the sequencer go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Raise a register beat and hold it until taken; the caller lowers valid
  // after the last write of a batch so back-to-back beats never toggle it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_write(idx, data);
  endtask

  task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row = '{ROW_WRITE, idx, data, 1'b0, '0};
    append_row(row);
  endtask

  task automatic add_sample(input logic [SAMPLE_W-1:0] raw);
    stim_row_t row;
    row = '{ROW_SAMPLE, '0, CFG_DATA_W'(raw), 1'b0, '0};
    append_row(row);
  endtask

  task automatic add_pinned(input logic [SAMPLE_W-1:0] raw, input logic [VAL_W-1:0] value,
                            input logic report, input logic active);
    stim_row_t row;
    row = '{ROW_SAMPLE, '0, CFG_DATA_W'(raw), 1'b1, '{value, report, active}};
    append_row(row);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: compare every accepted result beat with the oldest entry
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    gate_result_t due;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (results_due.size() == 0) begin
        note_mismatch("unexpected result beat", filtered_value_o, '0);
      end else begin
        due = results_due.pop_front();
        if (filtered_value_o !== due.value) begin
          note_mismatch("filtered_value", filtered_value_o, due.value);
        end
        if (report_o !== due.report) begin
          note_mismatch("report", 32'(report_o), 32'(due.report));
        end
        if (level_active_o !== due.active) begin
          note_mismatch("level_active", 32'(level_active_o), 32'(due.active));
        end
      end
    end
  end

  // Watchdog: end a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver side: stretches of one stall pattern each, plus a long hold-off
  // on request so the output register and the sequencer both back up.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    stall_mode_e mode;
    int          span;
    out_stall_i = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        for (int k = 0; k < HOLD_CYCLES; k++) begin
          @(posedge clk_i);
          out_stall_i <= 1'b1;
        end
      end
      mode = stall_mode_e'($urandom_range(0, 3));
      span = $urandom_range(4, 60);
      for (int k = 0; k < span; k++) begin
        @(posedge clk_i);
        case (mode)
          STALL_NONE:  out_stall_i <= 1'b0;
          STALL_COIN:  out_stall_i <= 1'($urandom_range(0, 1));
          STALL_HEAVY: out_stall_i <= (k % 4) != 3;
          default:     out_stall_i <= k[0];
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    stim_row_t           row;
    logic                cfg_open;
    int                  count;
    int                  level;
    logic                extreme;
    logic [31:0]         setting;
    sample_style_e       style;
    logic [SAMPLE_W-1:0] raw;

    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    raw_sample_i = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    mismatches   = 0;
    cycle_count  = 0;
    burst_left   = 0;
    hold_req     = 1'b0;

    // Reset values of the registers
    scale_q   = 32'sd65536;
    offset_q  = '0;
    alpha_q   = ONE_Q16;
    median_en = 1'b0;
    band_q    = '0;
    thresh_q  = '0;
    hyst_q    = '0;
    clear_filter();

    // Directed rows. With unity gain and a pass-through average the value is
    // just raw*65536, so the reset-state and saturation rows are typed in.
    add_pinned(16'h0000, 32'h0000_0000, 1'b1, 1'b0);   // first sample always reports
    add_pinned(16'h0001, 32'h0001_0000, 1'b1, 1'b0);
    add_pinned(16'h7FFF, 32'h7FFF_0000, 1'b1, 1'b0);
    add_pinned(16'h8000, 32'h8000_0000, 1'b1, 1'b0);
    add_pinned(16'h8000, 32'h8000_0000, 1'b0, 1'b0);   // no change, no report
    add_write(REG_CAL_SCALE, 32'h7FFF_FFFF);            // largest gain saturates both ways
    add_pinned(16'h7FFF, 32'h7FFF_FFFF, 1'b1, 1'b0);
    add_pinned(16'h8000, 32'h8000_0000, 1'b1, 1'b0);
    add_write(REG_CAL_SCALE, 32'h8000_0000);            // most negative gain
    add_pinned(16'h8000, 32'h7FFF_FFFF, 1'b1, 1'b0);
    add_write(REG_CAL_OFFSET, 32'h7FFF_FFFF);
    add_pinned(16'h0000, 32'h7FFF_FFFF, 1'b1, 1'b0);
    add_write(REG_CAL_SCALE, 32'h0001_0000);
    add_write(REG_CAL_OFFSET, 32'h0000_0000);
    add_pinned(16'h0005, 32'h0005_0000, 1'b1, 1'b0);
    add_write(REG_UNDEFINED, 32'hFFFF_FFFF);            // dropped: state must survive
    add_pinned(16'h0005, 32'h0005_0000, 1'b0, 1'b0);
    add_write(REG_THRESHOLD, 32'h000A_0000);            // band 9.0 .. 11.0
    add_write(REG_HYST_WIDTH, 32'h0001_0000);
    add_pinned(16'h000B, 32'h000B_0000, 1'b1, 1'b1);    // at upper edge: set
    add_pinned(16'h000A, 32'h000A_0000, 1'b1, 1'b1);    // inside band: hold
    add_pinned(16'h0009, 32'h0009_0000, 1'b1, 1'b0);    // at lower edge: clear
    add_write(REG_HYST_WIDTH, 32'h0000_0000);           // comparator off
    add_pinned(16'h0014, 32'h0014_0000, 1'b1, 1'b0);
    add_write(REG_EMA_ALPHA, 32'h0000_8000);            // half weight
    add_sample(16'h0000);
    add_sample(16'h0064);
    add_write(REG_EMA_ALPHA, 32'hFFFE_0000);            // upper bits ignored: alpha zero
    add_sample(16'h0032);
    add_sample(16'hFFCE);
    add_write(REG_EMA_ALPHA, 32'hFFFF_FFFF);            // alpha above one
    add_write(REG_MEDIAN_ON, 32'h0000_0001);
    add_sample(16'h0001);                               // window filling
    add_sample(16'h001E);
    add_sample(16'h0002);                               // first true median
    add_sample(16'h0003);                               // window shifts
    add_write(REG_MEDIAN_ON, 32'hFFFF_FFFE);            // bit 0 clear: median off
    add_write(REG_DEADBAND, 32'hFFFF_FFFF);             // widest deadband
    add_pinned(16'h0064, 32'h0064_0000, 1'b1, 1'b0);
    add_write(REG_THRESHOLD, 32'h8000_0000);            // band runs past the lower rail
    add_write(REG_HYST_WIDTH, 32'h7FFF_FFFF);
    add_sample(16'h0000);
    add_sample(16'h8000);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the table; drain before each batch of register beats
    cfg_open = 1'b0;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        if (!cfg_open) begin
          settle();
          cfg_open = 1'b1;
        end
        write_reg(row.idx, row.data);
      end else begin
        if (cfg_open) begin
          cfg_valid_i <= 1'b0;
          cfg_open = 1'b0;
        end
        send_sample(row.data[SAMPLE_W-1:0], row.pinned, row.want);
      end
    end

    // Random phases: fresh settings, then a stream of samples of one style
    for (int p = 0; p < PHASES; p++) begin
      settle();
      extreme = (p % 5 == 2);
      for (int r = REG_CAL_SCALE; r <= REG_HYST_WIDTH; r++) begin
        case (r)
          REG_CAL_SCALE: begin
            if (extreme) begin
              setting = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            end else begin
              case ($urandom_range(0, 3))
                0:       setting = 32'h0001_0000;
                1:       setting = $urandom;
                default: begin
                  setting = $urandom_range(0, 4 * 65536);
                  if ($urandom_range(0, 1)) setting = -setting;
                end
              endcase
            end
          end
          REG_CAL_OFFSET, REG_THRESHOLD: begin
            if (extreme) begin
              setting = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            end else begin
              case ($urandom_range(0, 3))
                0:       setting = '0;
                1:       setting = $urandom;
                default: begin
                  setting = $urandom_range(0, 1 << 22);
                  if ($urandom_range(0, 1)) setting = -setting;
                end
              endcase
            end
          end
          REG_EMA_ALPHA: begin
            if (extreme) begin
              setting = $urandom_range(0, 1) ? 32'd1 : 32'd65536;
            end else begin
              case ($urandom_range(0, 4))
                0:       setting = 32'd0;
                1:       setting = 32'd65535;
                2:       setting = $urandom_range(65536, 131071);
                default: setting = $urandom_range(1, 65535);
              endcase
            end
            // Bits above the register are noise
            setting = setting | ($urandom & 32'hFFFE_0000);
          end
          REG_MEDIAN_ON: setting = $urandom;
          default: begin
            // Deadband and half-width share a shape
            if (extreme) begin
              setting = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h0000_0000;
            end else begin
              case ($urandom_range(0, 3))
                0:       setting = '0;
                1:       setting = $urandom;
                default: setting = $urandom_range(1, 1 << 20);
              endcase
            end
            setting[31] = 1'($urandom_range(0, 1));
          end
        endcase
        write_reg(r[CFG_IDX_W-1:0], setting);
        if ($urandom_range(0, 7) == 0) write_reg(REG_UNDEFINED, $urandom);
      end
      cfg_valid_i <= 1'b0;

      // Back up the block in every fourth phase while samples keep coming
      if (p % 4 == 1) hold_req = 1'b1;

      style = sample_style_e'($urandom_range(0, 2));
      count = $urandom_range(95, 125);
      level = $urandom_range(0, 2000) - 1000;
      repeat (count) begin
        level = level + $urandom_range(0, 400) - 200;
        if (level > 32767) level = 32767;
        if (level < -32768) level = -32768;
        case (style)
          WANDER:  raw = SAMPLE_W'(level);
          SPIKY:   raw = ($urandom_range(0, 7) == 0) ? SAMPLE_W'($urandom) : SAMPLE_W'(level);
          default: raw = SAMPLE_W'($urandom);
        endcase
        send_sample(raw, 1'b0, '0);
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
